[hw/rtl/sdu_pkg.sv]
// shared types, constants and the arctangent table of the steering decision unit
package sdu_pkg;

    localparam int POS_W      = 24;
    localparam int ANG_W      = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int DIST_W     = 25;
    localparam int LIMIT_W    = 15;
    localparam int XY_W       = 44;
    localparam int Z_W        = 28;
    localparam int ROOT_W     = 51;
    localparam int SQ_W       = 50;
    localparam int ATAN_STEPS = 24;
    localparam int SQRT_STEPS = 25;
    localparam int ATAN_IDX_W = 5;
    localparam int REG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [Z_W-1:0]    PI_Q24     = 28'sd52707179;
    localparam logic signed [Z_W-1:0]    PI_Q13_Z   = 28'sd25736;
    localparam logic signed [Z_W-1:0]    ROUND_Q13  = 28'sd1024;
    localparam logic signed [17:0]       PI_Q13     = 18'sd25736;
    localparam logic signed [17:0]       TWO_PI_Q13 = 18'sd51472;

    localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST  = 15'd819;
    localparam logic [POS_W-1:0]   ARRIVE_RADIUS_RST = 24'd6554;

    localparam logic [REG_IDX_W-1:0] REG_ANGLE_LIMIT   = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_ARRIVE_RADIUS = 1'd1;

    typedef enum logic [1:0] {
        CMD_STOP     = 2'd0,
        CMD_TURN_POS = 2'd1,
        CMD_TURN_NEG = 2'd2,
        CMD_AHEAD    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pose_x;
        logic signed [POS_W-1:0] pose_y;
        logic signed [ANG_W-1:0] heading;
        logic signed [POS_W-1:0] goal_x;
        logic signed [POS_W-1:0] goal_y;
    } in_t;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [ANG_W-1:0] target_heading;
        logic signed [ANG_W-1:0] heading_error;
        logic [DIST_W-1:0]       goal_distance;
    } out_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] angle_limit;
        logic [POS_W-1:0]   arrive_radius;
    } cfg_t;

    // one slot of the rotation / square root chain
    typedef struct packed {
        logic                    vld;
        logic                    zero;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
        logic [ROOT_W-1:0]       rem;
        logic [ROOT_W-1:0]       root;
        logic signed [ANG_W-1:0] hd;
    } cell_t;

    // atan(2^-i) in Q.24 radians, rounded
    function automatic logic signed [Z_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/sdu_front.sv]
// front stages: goal vector, squares, quadrant pre-rotation and squared length
module sdu_front
    import sdu_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_vld,
    input  in_t   in_data,
    output cell_t c_out
);

    // stage a: vector to goal
    logic                     a_vld_reg;
    logic signed [DIFF_W-1:0] a_dx_reg, a_dy_reg;
    logic signed [ANG_W-1:0]  a_hd_reg;
    logic signed [DIFF_W-1:0] a_dx_next, a_dy_next;

    // stage b: squares and pre-rotation
    logic                     b_vld_reg, b_zero_reg;
    logic [SQ_W-2:0]          b_sqx_reg, b_sqy_reg;
    logic signed [XY_W-1:0]   b_x_reg, b_y_reg;
    logic signed [Z_W-1:0]    b_z_reg;
    logic signed [ANG_W-1:0]  b_hd_reg;
    logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
    logic signed [XY_W-1:0]   x0, y0, b_x_next, b_y_next;
    logic signed [Z_W-1:0]    b_z_next;

    // stage c: squared length
    cell_t c_reg, c_next;

    assign a_dx_next = $signed({in_data.goal_x[POS_W-1], in_data.goal_x})
                     - $signed({in_data.pose_x[POS_W-1], in_data.pose_x});
    assign a_dy_next = $signed({in_data.goal_y[POS_W-1], in_data.goal_y})
                     - $signed({in_data.pose_y[POS_W-1], in_data.pose_y});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
            a_dx_reg  <= a_dx_next;
            a_dy_reg  <= a_dy_next;
            a_hd_reg  <= in_data.heading;
        end
    end

    assign sqx_full = a_dx_reg * a_dx_reg;
    assign sqy_full = a_dy_reg * a_dy_reg;

    // vector scaled by 2^16 for the rotation
    assign x0 = $signed({{(XY_W-DIFF_W-16){a_dx_reg[DIFF_W-1]}}, a_dx_reg, 16'd0});
    assign y0 = $signed({{(XY_W-DIFF_W-16){a_dy_reg[DIFF_W-1]}}, a_dy_reg, 16'd0});

    always_comb begin
        b_x_next = x0;
        b_y_next = y0;
        b_z_next = '0;
        // left half plane: rotate by pi first
        if (a_dx_reg[DIFF_W-1]) begin
            b_x_next = -x0;
            b_y_next = -y0;
            b_z_next = a_dy_reg[DIFF_W-1] ? -PI_Q24 : PI_Q24;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg  <= a_vld_reg;
            b_zero_reg <= (a_dx_reg == '0) && (a_dy_reg == '0);
            b_sqx_reg  <= sqx_full[SQ_W-2:0];
            b_sqy_reg  <= sqy_full[SQ_W-2:0];
            b_x_reg    <= b_x_next;
            b_y_reg    <= b_y_next;
            b_z_reg    <= b_z_next;
            b_hd_reg   <= a_hd_reg;
        end
    end

    always_comb begin
        c_next.vld  = b_vld_reg;
        c_next.zero = b_zero_reg;
        c_next.x    = b_x_reg;
        c_next.y    = b_y_reg;
        c_next.z    = b_z_reg;
        c_next.rem  = ROOT_W'(b_sqx_reg) + ROOT_W'(b_sqy_reg);
        c_next.root = '0;
        c_next.hd   = b_hd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.vld <= 1'b0;
        end else if (en) begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;

endmodule

[hw/rtl/sdu_cell.sv]
// one chain cell: a cordic vectoring step (when ROTATE is set) and one bit of the integer square root
module sdu_cell
    import sdu_pkg::*;
#(
    parameter int IDX    = 0,
    parameter bit ROTATE = 1'b1
)
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cell_t c_in,
    output cell_t c_out
);

    localparam logic [ROOT_W-1:0] SQ_BIT = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - IDX));

    cell_t                  cell_reg, cell_next;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  ang;
    logic [ROOT_W-1:0]      trial;

    assign xs    = c_in.x >>> IDX;
    assign ys    = c_in.y >>> IDX;
    assign ang   = atan_q24(ATAN_IDX_W'(IDX));
    assign trial = c_in.root + SQ_BIT;

    always_comb begin
        cell_next = c_in;
        if (ROTATE) begin
            // drive y toward zero
            if (!c_in.y[XY_W-1]) begin
                cell_next.x = c_in.x + ys;
                cell_next.y = c_in.y - xs;
                cell_next.z = c_in.z + ang;
            end else begin
                cell_next.x = c_in.x - ys;
                cell_next.y = c_in.y + xs;
                cell_next.z = c_in.z - ang;
            end
        end
        if (c_in.rem >= trial) begin
            cell_next.rem  = c_in.rem - trial;
            cell_next.root = (c_in.root >> 1) + SQ_BIT;
        end else begin
            cell_next.root = c_in.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign c_out = cell_reg;

endmodule

[hw/rtl/sdu_back.sv]
// back stages: angle rounding and clamp, error wrap, command choice, output register
module sdu_back
    import sdu_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cfg_t  cfg,
    input  cell_t c_in,
    output logic  out_vld,
    output out_t  out_data
);

    logic                    d_vld_reg, d_near_reg;
    logic signed [ANG_W-1:0] d_tgt_reg, d_hd_reg, d_tgt_next;
    logic [DIST_W-1:0]       d_dist_reg, root_dist;
    logic signed [Z_W-1:0]   zr;

    logic signed [17:0]      e0, err, lim;
    cmd_t                    cmd;
    logic                    out_vld_reg;
    out_t                    out_reg, out_next;

    assign zr        = (c_in.z + ROUND_Q13) >>> 11;
    assign root_dist = c_in.root[DIST_W-1:0];

    always_comb begin
        priority if (c_in.zero) begin
            d_tgt_next = '0;
        end else if (zr > PI_Q13_Z) begin
            d_tgt_next = ANG_W'(PI_Q13_Z);
        end else if (zr < -PI_Q13_Z) begin
            d_tgt_next = ANG_W'(-PI_Q13_Z);
        end else begin
            d_tgt_next = zr[ANG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg  <= c_in.vld;
            d_tgt_reg  <= d_tgt_next;
            d_hd_reg   <= c_in.hd;
            d_dist_reg <= root_dist;
            d_near_reg <= root_dist < {1'b0, cfg.arrive_radius};
        end
    end

    assign e0  = $signed({{2{d_tgt_reg[ANG_W-1]}}, d_tgt_reg})
               - $signed({{2{d_hd_reg[ANG_W-1]}}, d_hd_reg});
    assign lim = $signed({3'b000, cfg.angle_limit});

    always_comb begin
        priority if (e0 <= -PI_Q13) begin
            err = e0 + TWO_PI_Q13;
        end else if (e0 > PI_Q13) begin
            err = e0 - TWO_PI_Q13;
        end else begin
            err = e0;
        end
    end

    always_comb begin
        priority if (d_near_reg) begin
            cmd = CMD_STOP;
        end else if (err > lim) begin
            cmd = CMD_TURN_POS;
        end else if (err < -lim) begin
            cmd = CMD_TURN_NEG;
        end else begin
            cmd = CMD_AHEAD;
        end
    end

    always_comb begin
        out_next.command        = cmd;
        out_next.target_heading = d_tgt_reg;
        out_next.heading_error  = err[ANG_W-1:0];
        out_next.goal_distance  = d_dist_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= d_vld_reg;
            out_reg     <= out_next;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_reg;

endmodule

[hw/rtl/go_to_goal_steering_decision_unit.sv]
// path to m_valid: front stages a, b, c, the 25 chain cells, back stages d and out
// throughput: one transaction per cycle unless stalled; each of 25 cells takes
//   one root bit, the first CORDIC_STEPS cells also a cordic rotation, so a pose
//   moves one cell each cycle; all stages hold while a result waits on m_ready
// reset: aresetn low clears all valid flags and loads the default angle_limit
//   and arrive_radius
module go_to_goal_steering_decision_unit
    import sdu_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t  cfg_reg;
    logic  en;
    cell_t chain [0:SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.angle_limit   <= ANGLE_LIMIT_RST;
            cfg_reg.arrive_radius <= ARRIVE_RADIUS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ANGLE_LIMIT:   cfg_reg.angle_limit   <= cfg_wdata[LIMIT_W-1:0];
                REG_ARRIVE_RADIUS: cfg_reg.arrive_radius <= cfg_wdata[POS_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    sdu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_valid),
        .in_data (s_data),
        .c_out   (chain[0])
    );

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
        sdu_cell #(
            .IDX    (k),
            .ROTATE ((k < CORDIC_STEPS) && (k < ATAN_STEPS))
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .c_in    (chain[k]),
            .c_out   (chain[k+1])
        );
    end

    sdu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .cfg      (cfg_reg),
        .c_in     (chain[SQRT_STEPS]),
        .out_vld  (m_valid),
        .out_data (m_data)
    );

`ifndef ASSERT_OFF
    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_data.heading_error) > -$signed(PI_Q13[ANG_W-1:0]))
                 && ($signed(m_data.heading_error) <= $signed(PI_Q13[ANG_W-1:0])))
        else $error("heading error outside the wrapped range");

    a_tgt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_data.target_heading) >= -$signed(PI_Q13[ANG_W-1:0]))
                 && ($signed(m_data.target_heading) <= $signed(PI_Q13[ANG_W-1:0])))
        else $error("target heading outside plus or minus pi");

    a_stop_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.command != CMD_STOP))
            |-> (m_data.goal_distance >= {1'b0, cfg_reg.arrive_radius}))
        else $error("drive command issued inside the arrive radius");

    a_turn_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.command == CMD_TURN_POS))
            |-> ($signed(m_data.heading_error) > $signed({1'b0, cfg_reg.angle_limit})))
        else $error("positive turn inside the dead band");
`endif

endmodule

[verif/testbench.sv]
// testbench for the go-to-goal steering decision unit: directed and random poses checked
// against a predictor
`timescale 1ns / 1ps

module testbench;
    import sdu_pkg::*;

    localparam int     STEPS         = 16;
    localparam int     RUN_LIMIT     = 200000;
    localparam int     SETTLE        = 40;
    localparam longint HALF_TURN_Q24 = 52707179;
    localparam longint HALF_TURN     = 25736;
    localparam longint FULL_TURN     = 51472;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_we;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic [LIMIT_W-1:0] ang_limit  = ANGLE_LIMIT_RST;
    logic [POS_W-1:0]   arr_radius = ARRIVE_RADIUS_RST;
    out_t               pending_decisions [$];
    int                 mismatch_count;
    bit                 steady;

    go_to_goal_steering_decision_unit #(
        .CORDIC_STEPS (STEPS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // expected decision for one pose under the current dead band and arrive radius
    function automatic out_t decide_steering(input in_t p);
        longint rot [24] = '{
            13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
            65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2
        };
        longint          dx, dy, x, y, z, t, err, lim;
        longint unsigned rem, root, bitv;
        cmd_t            cmd;
        out_t            r;
        dx = longint'($signed(p.goal_x)) - longint'($signed(p.pose_x));
        dy = longint'($signed(p.goal_y)) - longint'($signed(p.pose_y));

        rem  = longint'(dx * dx + dy * dy);
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end

        z = 0;
        if (dx != 0 || dy != 0) begin
            x = dx * 65536;
            y = dy * 65536;
            // left half plane: rotate by half a turn first
            if (x < 0) begin
                z = (y >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS && i < 24; i++) begin
                if (y >= 0) begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + rot[i];
                end else begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - rot[i];
                end
                x = t;
            end
            z = (z + 1024) >>> 11;
            if (z > HALF_TURN) z = HALF_TURN;
            if (z < -HALF_TURN) z = -HALF_TURN;
        end

        err = z - longint'($signed(p.heading));
        if (err <= -HALF_TURN) err = err + FULL_TURN;
        else if (err > HALF_TURN) err = err - FULL_TURN;

        lim = longint'(ang_limit);
        if (root < longint'(arr_radius)) cmd = CMD_STOP;
        else if (err > lim) cmd = CMD_TURN_POS;
        else if (err < -lim) cmd = CMD_TURN_NEG;
        else cmd = CMD_AHEAD;

        r.command        = cmd;
        r.target_heading = z[ANG_W-1:0];
        r.heading_error  = err[ANG_W-1:0];
        r.goal_distance  = root[DIST_W-1:0];
        return r;
    endfunction

    function automatic in_t make_pose(input int px, input int py, input int hd,
                                      input int gx, input int gy);
        in_t p;
        p.pose_x  = POS_W'(px);
        p.pose_y  = POS_W'(py);
        p.heading = ANG_W'(hd);
        p.goal_x  = POS_W'(gx);
        p.goal_y  = POS_W'(gy);
        return p;
    endfunction

    // choose the heading so that the heading error lands on err_want
    function automatic in_t aim_error(input in_t p, input int err_want);
        out_t d;
        d = decide_steering(p);
        p.heading = ANG_W'(int'($signed(d.target_heading)) - err_want);
        return p;
    endfunction

    function automatic in_t random_pose();
        in_t p;
        p.pose_x = POS_W'($urandom());
        p.pose_y = POS_W'($urandom());
        p.goal_x = POS_W'($urandom());
        p.goal_y = POS_W'($urandom());
        if ($urandom_range(0, 7) == 0) p.heading = ANG_W'($urandom());
        else p.heading = ANG_W'($urandom_range(0, 51472) - 25736);
        return p;
    endfunction

    // goal close to the robot, around the arrive radius
    function automatic in_t near_pose();
        in_t p;
        int  span;
        p    = random_pose();
        span = ((arr_radius > 24'd1048576) ? 1048576 : int'(arr_radius)) + 16;
        p.goal_x = p.pose_x + POS_W'(int'($urandom_range(0, 2 * span)) - span);
        p.goal_y = p.pose_y + POS_W'(int'($urandom_range(0, 2 * span)) - span);
        return p;
    endfunction

    function automatic in_t mixed_pose();
        in_t p;
        int  pick;
        int  e;
        pick = $urandom_range(0, 9);
        if (pick < 4) return random_pose();
        if (pick < 7) return near_pose();
        // heading error right around the dead band edge
        p = random_pose();
        e = int'(ang_limit) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) e = -e;
        return aim_error(p, e);
    endfunction

    task automatic send_pose(input in_t p);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ANGLE_LIMIT:   ang_limit  = val[LIMIT_W-1:0];
            REG_ARRIVE_RADIUS: arr_radius = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int lim, input int rad);
        wait_idle();
        write_register(REG_ANGLE_LIMIT, CFG_DATA_W'(lim));
        write_register(REG_ARRIVE_RADIUS, CFG_DATA_W'(rad));
    endtask

    task automatic test_directed();
        in_t p;
        // zero vector, in the middle and at the corner
        send_pose(make_pose(0, 0, 0, 0, 0));
        send_pose(make_pose(-8388608, -8388608, 25736, -8388608, -8388608));
        // longest vectors along each axis and both diagonals
        send_pose(make_pose(-8388608, 0, 0, 8388607, 0));
        send_pose(make_pose(8388607, 0, 0, -8388608, 0));
        send_pose(make_pose(0, -8388608, 0, 0, 8388607));
        send_pose(make_pose(0, 8388607, 0, 0, -8388608));
        send_pose(make_pose(-8388608, -8388608, -25736, 8388607, 8388607));
        send_pose(make_pose(8388607, -8388608, 25736, -8388608, 8388607));
        // left half plane, on, just below and just above the x axis
        send_pose(make_pose(100, 0, 25736, 0, 0));
        send_pose(make_pose(100, 1, -25736, 0, 0));
        send_pose(make_pose(100, -1, 0, 0, 0));
        // distance one below and exactly at the arrive radius
        send_pose(make_pose(0, 0, 0, 6553, 0));
        send_pose(make_pose(0, 0, 0, 6554, 0));
        // headings outside plus or minus pi
        send_pose(make_pose(0, 0, 32767, 500000, -300000));
        send_pose(make_pose(0, 0, -32768, -500000, 300000));
        send_pose(make_pose(0, 0, 25737, -400000, 1));
        // heading error on and just past the dead band edges
        p = make_pose(1000, -2000, 0, 700000, 900000);
        send_pose(aim_error(p, 819));
        send_pose(aim_error(p, 820));
        send_pose(aim_error(p, -819));
        send_pose(aim_error(p, -820));
        send_pose(aim_error(p, 0));
    endtask

    task automatic test_config_extremes();
        apply_setting(0, 0);
        repeat (70) send_pose(mixed_pose());
        apply_setting(25736, 16777215);
        repeat (70) send_pose(mixed_pose());
        apply_setting(25736, 0);
        repeat (70) send_pose(mixed_pose());
        apply_setting(0, 16777215);
        repeat (70) send_pose(mixed_pose());
        apply_setting($urandom_range(0, 25736), $urandom_range(0, 262144));
        repeat (70) send_pose(mixed_pose());
        apply_setting(ANGLE_LIMIT_RST, ARRIVE_RADIUS_RST);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (150) send_pose(mixed_pose());
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        repeat (200) send_pose(mixed_pose());
        // hold off until the pipe has emptied, then carry on
        wait_idle();
        repeat (200) send_pose(mixed_pose());
    endtask

    // result side: random back-pressure, none while steady is set
    initial begin
        int hold;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 3);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) pending_decisions.push_back(decide_steering(s_data));
            if (m_valid && m_ready) begin
                if (pending_decisions.size() == 0) begin
                    $display("%0t: result transaction with nothing expected, got %h",
                             $time, m_data);
                    mismatch_count++;
                end else begin
                    want = pending_decisions.pop_front();
                    if (m_data.command !== want.command) begin
                        $display("%0t: command expected %0d, got %0d",
                                 $time, want.command, m_data.command);
                        mismatch_count++;
                    end
                    if (m_data.target_heading !== want.target_heading) begin
                        $display("%0t: target_heading expected %0d, got %0d",
                                 $time, want.target_heading, m_data.target_heading);
                        mismatch_count++;
                    end
                    if (m_data.heading_error !== want.heading_error) begin
                        $display("%0t: heading_error expected %0d, got %0d",
                                 $time, want.heading_error, m_data.heading_error);
                        mismatch_count++;
                    end
                    if (m_data.goal_distance !== want.goal_distance) begin
                        $display("%0t: goal_distance expected %0d, got %0d",
                                 $time, want.goal_distance, m_data.goal_distance);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        mismatch_count = 0;
        steady         = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_config_extremes();
        test_back_to_back();
        test_random_traffic();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sdu_pkg.sv
hw/rtl/sdu_front.sv
hw/rtl/sdu_cell.sv
hw/rtl/sdu_back.sv
hw/rtl/go_to_goal_steering_decision_unit.sv
verif/testbench.sv
